/* src/oft_pkg.sv */
// ----------------------------------------------------------------------------
// oft_pkg: open file offset table shared types
// Beat formats, operation and status codes, sequencer states and the
// control/flag bundles passed between the sequencer and the datapath.
// ----------------------------------------------------------------------------
package oft_pkg;

   localparam int KEY_IN_W    = 16;
   localparam int OFFSET_W    = 31;
   localparam int COUNT_OUT_W = 5;
   localparam int ACTION_W    = 3;
   localparam int STATUS_W    = 2;

   typedef enum logic [ACTION_W-1:0] {
      ACT_INSERT = 3'd0,
      ACT_REMOVE = 3'd1,
      ACT_GET    = 3'd2,
      ACT_SET    = 3'd3,
      ACT_CLEAR  = 3'd4
   } action_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK      = 2'd0,
      STAT_FULL    = 2'd1,
      STAT_MISSING = 2'd2
   } status_type;

   typedef struct packed {
      logic [ACTION_W-1:0] action;
      logic [KEY_IN_W-1:0] key_inode;
      logic [OFFSET_W-1:0] offset_in;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0]    status;
      logic [OFFSET_W-1:0]    offset_out;
      logic [COUNT_OUT_W-1:0] entry_count;
   } rsp_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_SCAN_RD,
      S_SCAN_CMP,
      S_SHIFT_RD,
      S_SHIFT_WR
   } state_type;

   typedef enum logic {
      RD_IDX,
      RD_NEXT
   } rd_sel_type;

   typedef enum logic [1:0] {
      WR_INSERT,
      WR_SET,
      WR_SHIFT
   } wr_sel_type;

   typedef struct packed {
      logic       ld_req;
      logic       rd_en;
      rd_sel_type rd_sel;
      logic       we;
      wr_sel_type wr_sel;
      logic       idx_clr;
      logic       idx_inc;
      logic       cnt_inc;
      logic       cnt_dec;
      logic       cnt_clr;
      logic       finish;
      status_type status;
      logic       hit_out;
   } ctrl_type;

   typedef struct packed {
      logic [ACTION_W-1:0] action;
      logic                full;
      logic                empty;
      logic                hit;
      logic                last;
      logic                shift_last;
   } flags_type;

endpackage

/* src/oft_ram.sv */
// ----------------------------------------------------------------------------
// oft_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module oft_ram #(
   parameter int WIDTH = 47,
   parameter int DEPTH = 16
) (
   input  logic                                       clock,
   input  logic                                       we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                           wdata,
   input  logic                                       re,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                           rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

/* src/oft_ctrl.sv */
// ----------------------------------------------------------------------------
// oft_ctrl: open file offset table sequencer
// Walks the table one slot at a time for lookups and compaction.
// ----------------------------------------------------------------------------
module oft_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  oft_pkg::flags_type flags,
   output logic              busy,
   output oft_pkg::ctrl_type ctrl
);

   oft_pkg::state_type state_ff;
   oft_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= oft_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         oft_pkg::S_IDLE: begin
            if (start) begin
               state_in = oft_pkg::S_EXEC;
            end
         end
         oft_pkg::S_EXEC: begin
            if ((flags.action inside {oft_pkg::ACT_REMOVE, oft_pkg::ACT_GET,
                                      oft_pkg::ACT_SET}) && !flags.empty) begin
               state_in = oft_pkg::S_SCAN_RD;
            end else begin
               state_in = oft_pkg::S_IDLE;
            end
         end
         oft_pkg::S_SCAN_RD: begin
            state_in = oft_pkg::S_SCAN_CMP;
         end
         oft_pkg::S_SCAN_CMP: begin
            if (flags.hit) begin
               if (flags.action == oft_pkg::ACT_REMOVE && !flags.last) begin
                  state_in = oft_pkg::S_SHIFT_RD;
               end else begin
                  state_in = oft_pkg::S_IDLE;
               end
            end else if (flags.last) begin
               state_in = oft_pkg::S_IDLE;
            end else begin
               state_in = oft_pkg::S_SCAN_RD;
            end
         end
         oft_pkg::S_SHIFT_RD: begin
            state_in = oft_pkg::S_SHIFT_WR;
         end
         oft_pkg::S_SHIFT_WR: begin
            if (flags.shift_last) begin
               state_in = oft_pkg::S_IDLE;
            end else begin
               state_in = oft_pkg::S_SHIFT_RD;
            end
         end
         default: begin
            state_in = oft_pkg::S_IDLE;
         end
      endcase
   end

   always_comb begin
      ctrl        = '0;
      ctrl.status = oft_pkg::STAT_OK;
      busy        = (state_ff != oft_pkg::S_IDLE);
      case (state_ff)
         oft_pkg::S_IDLE: begin
            ctrl.ld_req = start;
         end
         oft_pkg::S_EXEC: begin
            case (flags.action)
               oft_pkg::ACT_INSERT: begin
                  ctrl.finish = 1'b1;
                  if (flags.full) begin
                     ctrl.status = oft_pkg::STAT_FULL;
                  end else begin
                     ctrl.we      = 1'b1;
                     ctrl.wr_sel  = oft_pkg::WR_INSERT;
                     ctrl.cnt_inc = 1'b1;
                  end
               end
               oft_pkg::ACT_CLEAR: begin
                  ctrl.cnt_clr = 1'b1;
                  ctrl.finish  = 1'b1;
               end
               oft_pkg::ACT_REMOVE, oft_pkg::ACT_GET, oft_pkg::ACT_SET: begin
                  if (flags.empty) begin
                     ctrl.status = oft_pkg::STAT_MISSING;
                     ctrl.finish = 1'b1;
                  end else begin
                     ctrl.idx_clr = 1'b1;
                  end
               end
               default: begin
                  ctrl.finish = 1'b1;
               end
            endcase
         end
         oft_pkg::S_SCAN_RD: begin
            ctrl.rd_en  = 1'b1;
            ctrl.rd_sel = oft_pkg::RD_IDX;
         end
         oft_pkg::S_SCAN_CMP: begin
            if (flags.hit) begin
               case (flags.action)
                  oft_pkg::ACT_GET: begin
                     ctrl.hit_out = 1'b1;
                     ctrl.finish  = 1'b1;
                  end
                  oft_pkg::ACT_SET: begin
                     ctrl.we     = 1'b1;
                     ctrl.wr_sel = oft_pkg::WR_SET;
                     ctrl.finish = 1'b1;
                  end
                  oft_pkg::ACT_REMOVE: begin
                     if (flags.last) begin
                        ctrl.cnt_dec = 1'b1;
                        ctrl.finish  = 1'b1;
                     end
                  end
                  default: begin
                     ctrl.finish = 1'b1;
                  end
               endcase
            end else if (flags.last) begin
               ctrl.status = oft_pkg::STAT_MISSING;
               ctrl.finish = 1'b1;
            end else begin
               ctrl.idx_inc = 1'b1;
            end
         end
         oft_pkg::S_SHIFT_RD: begin
            ctrl.rd_en  = 1'b1;
            ctrl.rd_sel = oft_pkg::RD_NEXT;
         end
         oft_pkg::S_SHIFT_WR: begin
            ctrl.we     = 1'b1;
            ctrl.wr_sel = oft_pkg::WR_SHIFT;
            if (flags.shift_last) begin
               ctrl.cnt_dec = 1'b1;
               ctrl.finish  = 1'b1;
            end else begin
               ctrl.idx_inc = 1'b1;
            end
         end
         default: begin
            ctrl = '0;
         end
      endcase
   end

endmodule

/* src/oft_dpath.sv */
// ----------------------------------------------------------------------------
// oft_dpath: open file offset table datapath
// Request register, slot index, entry count, the shared key comparator,
// RAM address/data selection and the result register.
// ----------------------------------------------------------------------------
module oft_dpath #(
   parameter int TABLE_DEPTH = 16,
   parameter int KEY_BITS    = 16,
   localparam int AW     = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
   localparam int CNT_W  = $clog2(TABLE_DEPTH + 1),
   localparam int DATA_W = KEY_BITS + oft_pkg::OFFSET_W
) (
   input  logic               clock,
   input  logic               reset,
   input  oft_pkg::req_type   req_data,
   input  oft_pkg::ctrl_type  ctrl,
   output oft_pkg::flags_type flags,
   output logic               ram_we,
   output logic [AW-1:0]      ram_waddr,
   output logic [DATA_W-1:0]  ram_wdata,
   output logic               ram_re,
   output logic [AW-1:0]      ram_raddr,
   input  logic [DATA_W-1:0]  ram_rdata,
   output logic               rsp_valid,
   output oft_pkg::rsp_type   rsp_data
);

   localparam int EXT_W = CNT_W + 1;
   localparam int OW    = oft_pkg::OFFSET_W;
   localparam int CW    = oft_pkg::COUNT_OUT_W;

   oft_pkg::req_type req_ff;
   logic [AW-1:0]    idx_ff;
   logic [AW-1:0]    idx_in;
   logic [CNT_W-1:0] cnt_ff;
   logic [CNT_W-1:0] cnt_in;
   logic             rsp_valid_ff;
   oft_pkg::rsp_type rsp_data_ff;
   oft_pkg::rsp_type rsp_data_in;

   logic [KEY_BITS-1:0] key_cmp;
   logic [KEY_BITS-1:0] rd_key;
   logic [OW-1:0]       rd_offs;
   logic [EXT_W-1:0]    idx_ext;
   logic [EXT_W-1:0]    cnt_ext;
   logic [CW-1:0]       cnt_out;

   if (KEY_BITS > oft_pkg::KEY_IN_W) begin : g_key_wide
      assign key_cmp = {{(KEY_BITS - oft_pkg::KEY_IN_W){1'b0}}, req_ff.key_inode};
   end else if (KEY_BITS == oft_pkg::KEY_IN_W) begin : g_key_same
      assign key_cmp = req_ff.key_inode;
   end else begin : g_key_narrow
      assign key_cmp = req_ff.key_inode[KEY_BITS-1:0];
   end

   if (CNT_W >= CW) begin : g_cnt_wide
      assign cnt_out = cnt_in[CW-1:0];
   end else begin : g_cnt_narrow
      assign cnt_out = {{(CW - CNT_W){1'b0}}, cnt_in};
   end

   assign rd_key  = ram_rdata[DATA_W-1:OW];
   assign rd_offs = ram_rdata[OW-1:0];
   assign idx_ext = {{(EXT_W - AW){1'b0}}, idx_ff};
   assign cnt_ext = {1'b0, cnt_ff};

   assign flags.action     = req_ff.action;
   assign flags.full       = (cnt_ff == CNT_W'(TABLE_DEPTH));
   assign flags.empty      = (cnt_ff == '0);
   assign flags.hit        = (rd_key == key_cmp);
   assign flags.last       = ((idx_ext + EXT_W'(1)) >= cnt_ext);
   assign flags.shift_last = ((idx_ext + EXT_W'(2)) >= cnt_ext);

   always_comb begin
      idx_in = idx_ff;
      if (ctrl.idx_clr) begin
         idx_in = '0;
      end else if (ctrl.idx_inc) begin
         idx_in = idx_ff + AW'(1);
      end
   end

   always_comb begin
      cnt_in = cnt_ff;
      if (ctrl.cnt_clr) begin
         cnt_in = '0;
      end else if (ctrl.cnt_inc) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end else if (ctrl.cnt_dec) begin
         cnt_in = cnt_ff - CNT_W'(1);
      end
   end

   always_comb begin
      ram_we    = ctrl.we;
      ram_re    = ctrl.rd_en;
      ram_waddr = idx_ff;
      ram_wdata = ram_rdata;
      case (ctrl.wr_sel)
         oft_pkg::WR_INSERT: begin
            ram_waddr = cnt_ff[AW-1:0];
            ram_wdata = {key_cmp, req_ff.offset_in};
         end
         oft_pkg::WR_SET: begin
            ram_wdata = {rd_key, req_ff.offset_in};
         end
         oft_pkg::WR_SHIFT: begin
            ram_wdata = ram_rdata;
         end
         default: begin
            ram_wdata = ram_rdata;
         end
      endcase
      if (ctrl.rd_sel == oft_pkg::RD_NEXT) begin
         ram_raddr = idx_ff + AW'(1);
      end else begin
         ram_raddr = idx_ff;
      end
   end

   always_comb begin
      rsp_data_in.status      = ctrl.status;
      rsp_data_in.offset_out  = ctrl.hit_out ? rd_offs : '0;
      rsp_data_in.entry_count = cnt_out;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= ctrl.finish;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      if (ctrl.ld_req) begin
         req_ff <= req_data;
      end
      if (ctrl.finish) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

/* src/open_file_offset_table_top.sv */
// ----------------------------------------------------------------------------
// open_file_offset_table_top: table of open files with compacting remove
// Usage: drive req_data and raise start; the beat is taken at an edge where
// start is high and busy is low. busy stays high until the operation ends.
// Each beat yields exactly one result beat on rsp_data, marked by rsp_valid
// for a single cycle; the receiver cannot stall it.
// Steps after accept: insert, clear, an unknown code and a lookup on an empty
// table finish in the execute state; get/set/remove scan slots 0..k up to
// the matching slot k; remove then moves each later entry down one slot;
// a miss scans every entry. Each slot visited takes a registered read of the
// entry RAM, then the shared key compare or the shift write-back.
// A new beat may be accepted in the cycle that shows the previous result.
// Reset empties the table (count to zero); entry storage is not cleared
// and needs no clearing pass.
// ----------------------------------------------------------------------------
module open_file_offset_table_top #(
   parameter int TABLE_DEPTH = 16,
   parameter int KEY_BITS    = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  oft_pkg::req_type req_data,
   output logic             rsp_valid,
   output oft_pkg::rsp_type rsp_data
);

   localparam int AW     = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int DATA_W = KEY_BITS + oft_pkg::OFFSET_W;

   oft_pkg::ctrl_type  ctrl;
   oft_pkg::flags_type flags;
   logic               ram_we;
   logic [AW-1:0]      ram_waddr;
   logic [DATA_W-1:0]  ram_wdata;
   logic               ram_re;
   logic [AW-1:0]      ram_raddr;
   logic [DATA_W-1:0]  ram_rdata;

   oft_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .flags (flags),
      .busy  (busy),
      .ctrl  (ctrl)
   );

   oft_dpath #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .KEY_BITS    (KEY_BITS)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .ctrl      (ctrl),
      .flags     (flags),
      .ram_we    (ram_we),
      .ram_waddr (ram_waddr),
      .ram_wdata (ram_wdata),
      .ram_re    (ram_re),
      .ram_raddr (ram_raddr),
      .ram_rdata (ram_rdata),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   oft_ram #(
      .WIDTH (DATA_W),
      .DEPTH (TABLE_DEPTH)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

endmodule

/* src/oft_checker.sv */
// ----------------------------------------------------------------------------
// oft_checker: port-level checks for the open file offset table
// Observes the command and result ports only.
// ----------------------------------------------------------------------------
module oft_checker (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input logic             rsp_valid,
   input oft_pkg::rsp_type rsp_data
);

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy not raised after accepted beat");

   a_busy_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(busy) |-> $past(start))
      else $error("busy rose without an accepted beat");

   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result strobed while busy");

   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

   a_err_offset: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status != oft_pkg::STAT_OK) |-> (rsp_data.offset_out == '0))
      else $error("nonzero offset on failed operation");

endmodule

bind open_file_offset_table_top oft_checker u_oft_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);

/* tb/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: open file offset table testbench
// Drives insert/remove/get/set/clear beats and undefined action codes, and
// keeps a shadow copy of the table to predict each reply beat. Every reply is
// checked field by field against the oldest prediction. Directed cases come
// first: empty table, duplicate keys, full table, longest compaction, clear.
// Random traffic over a small pool of hot keys follows, with sender gaps.
// ----------------------------------------------------------------------------
module tb;

   localparam int ACTION_W    = oft_pkg::ACTION_W;
   localparam int OFFSET_W    = oft_pkg::OFFSET_W;
   localparam int KEY_IN_W    = oft_pkg::KEY_IN_W;
   localparam int COUNT_OUT_W = oft_pkg::COUNT_OUT_W;

   localparam int DEPTH = 16;
   localparam int KEY_W = 16;
   localparam int SETTLE_CYCLES = 80;
   localparam int POOL_SIZE = 6;
   localparam logic [ACTION_W-1:0] ACT_UNDEF_LO = 3'd5;
   localparam logic [ACTION_W-1:0] ACT_UNDEF_HI = 3'd7;
   localparam logic [OFFSET_W-1:0] OFFSET_MAX = {OFFSET_W{1'b1}};
   localparam logic [KEY_IN_W-1:0] KEY_MAX = {KEY_IN_W{1'b1}};

   logic             clock;
   logic             reset;
   logic             start;
   logic             busy;
   oft_pkg::req_type req_data;
   logic             rsp_valid;
   oft_pkg::rsp_type rsp_data;

   logic [KEY_IN_W-1:0] tbl_keys [DEPTH];
   logic [OFFSET_W-1:0] tbl_offsets [DEPTH];
   int                  tbl_count;
   logic [KEY_IN_W-1:0] hot_keys [POOL_SIZE];
   oft_pkg::rsp_type    due_replies [$];
   bit                  failed;

   open_file_offset_table_top #(
      .TABLE_DEPTH(DEPTH),
      .KEY_BITS   (KEY_W)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_data (rsp_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   initial begin
      #20_000_000;
      $display("== FAIL ==");
      $finish;
   end

   function automatic int find_slot(input logic [KEY_IN_W-1:0] key);
      for (int i = 0; i < tbl_count; i++)
         if (tbl_keys[i] == key)
            return i;
      return -1;
   endfunction

   function automatic oft_pkg::rsp_type apply_table_op(input oft_pkg::req_type op);
      oft_pkg::rsp_type r;
      int               slot;
      r.status     = oft_pkg::STAT_OK;
      r.offset_out = '0;
      case (op.action)
         oft_pkg::ACT_INSERT: begin
            if (tbl_count < DEPTH) begin
               tbl_keys[tbl_count]    = op.key_inode;
               tbl_offsets[tbl_count] = op.offset_in;
               tbl_count++;
            end else
               r.status = oft_pkg::STAT_FULL;
         end
         oft_pkg::ACT_REMOVE: begin
            slot = find_slot(op.key_inode);
            if (slot < 0)
               r.status = oft_pkg::STAT_MISSING;
            else begin
               for (int i = slot; i < tbl_count - 1; i++) begin
                  tbl_keys[i]    = tbl_keys[i + 1];
                  tbl_offsets[i] = tbl_offsets[i + 1];
               end
               tbl_count--;
            end
         end
         oft_pkg::ACT_GET: begin
            slot = find_slot(op.key_inode);
            if (slot < 0)
               r.status = oft_pkg::STAT_MISSING;
            else
               r.offset_out = tbl_offsets[slot];
         end
         oft_pkg::ACT_SET: begin
            slot = find_slot(op.key_inode);
            if (slot < 0)
               r.status = oft_pkg::STAT_MISSING;
            else
               tbl_offsets[slot] = op.offset_in;
         end
         oft_pkg::ACT_CLEAR: tbl_count = 0;
         default: ;
      endcase
      r.entry_count = tbl_count[COUNT_OUT_W-1:0];
      return r;
   endfunction

   // reply checker
   always @(posedge clock) begin
      oft_pkg::rsp_type want;
      if (!reset && rsp_valid) begin
         if (due_replies.size() == 0) begin
            $display("%0t: reply beat with none pending: %p", $time, rsp_data);
            failed = 1'b1;
         end else begin
            want = due_replies.pop_front();
            if (rsp_data.status !== want.status) begin
               $display("%0t: status exp %0d got %0d", $time, want.status, rsp_data.status);
               failed = 1'b1;
            end
            if (rsp_data.offset_out !== want.offset_out) begin
               $display("%0t: offset_out exp %h got %h", $time, want.offset_out,
                        rsp_data.offset_out);
               failed = 1'b1;
            end
            if (rsp_data.entry_count !== want.entry_count) begin
               $display("%0t: entry_count exp %0d got %0d", $time, want.entry_count,
                        rsp_data.entry_count);
               failed = 1'b1;
            end
         end
      end
   end

   // called at a falling edge; returns at the falling edge after the accept
   task automatic send_op(input logic [ACTION_W-1:0] action,
                          input logic [KEY_IN_W-1:0] key,
                          input logic [OFFSET_W-1:0] offset);
      oft_pkg::req_type op;
      op.action    = action;
      op.key_inode = key;
      op.offset_in = offset;
      start    <= 1'b1;
      req_data <= op;
      @(posedge clock);
      while (busy)
         @(posedge clock);
      due_replies.push_back(apply_table_op(op));
      @(negedge clock);
   endtask

   task automatic sender_gap(input int idle_pct);
      logic [63:0] junk;
      if ($urandom_range(99) < idle_pct) begin
         junk      = {$urandom(), $urandom()};
         start    <= 1'b0;
         req_data <= junk[$bits(oft_pkg::req_type)-1:0];
         repeat ($urandom_range(1, 4))
            @(negedge clock);
      end
   endtask

   task automatic drain_replies();
      start <= 1'b0;
      while (due_replies.size() != 0)
         @(posedge clock);
      @(negedge clock);
   endtask

   task automatic test_lookup_basics();
      send_op(oft_pkg::ACT_GET, 16'h1234, '0);
      send_op(oft_pkg::ACT_REMOVE, 16'h1234, '0);
      send_op(oft_pkg::ACT_INSERT, '0, '0);
      send_op(oft_pkg::ACT_INSERT, KEY_MAX, OFFSET_MAX);
      send_op(oft_pkg::ACT_INSERT, '0, 31'd5);
      send_op(oft_pkg::ACT_GET, '0, '0);
      send_op(oft_pkg::ACT_SET, '0, OFFSET_MAX);
      send_op(oft_pkg::ACT_REMOVE, '0, '0);
      send_op(oft_pkg::ACT_GET, '0, '0);
   endtask

   task automatic test_full_table();
      for (int i = 0; i < DEPTH - 2; i++)
         send_op(oft_pkg::ACT_INSERT, KEY_IN_W'(16'h0100 + i), OFFSET_W'($urandom()));
      send_op(oft_pkg::ACT_INSERT, 16'hBEEF, OFFSET_MAX);
      send_op(oft_pkg::ACT_GET, KEY_IN_W'(16'h0100 + DEPTH - 3), '0);
      // slot 0 of a full table: longest compaction
      send_op(oft_pkg::ACT_REMOVE, KEY_MAX, '0);
   endtask

   task automatic test_clear_and_undefined();
      send_op(oft_pkg::ACT_CLEAR, 16'h0101, '0);
      send_op(ACT_UNDEF_LO, KEY_MAX, OFFSET_MAX);
      send_op(ACT_UNDEF_HI, '0, '0);
   endtask

   task automatic refresh_hot_keys();
      for (int i = 0; i < POOL_SIZE; i++)
         case ($urandom_range(7))
            0:       hot_keys[i] = '0;
            1:       hot_keys[i] = KEY_MAX;
            default: hot_keys[i] = KEY_IN_W'($urandom());
         endcase
   endtask

   task automatic test_random(input int n_ops, input int idle_pct);
      int                  pick;
      logic [ACTION_W-1:0] action;
      logic [KEY_IN_W-1:0] key;
      logic [OFFSET_W-1:0] offset;
      for (int n = 0; n < n_ops; n++) begin
         if (n % 64 == 0)
            refresh_hot_keys();
         pick = $urandom_range(99);
         if (pick < 32)      action = oft_pkg::ACT_INSERT;
         else if (pick < 52) action = oft_pkg::ACT_REMOVE;
         else if (pick < 72) action = oft_pkg::ACT_GET;
         else if (pick < 91) action = oft_pkg::ACT_SET;
         else if (pick < 96) action = oft_pkg::ACT_CLEAR;
         else                action = ACTION_W'($urandom_range(ACT_UNDEF_HI, ACT_UNDEF_LO));
         if ($urandom_range(99) < 85)
            key = hot_keys[$urandom_range(POOL_SIZE - 1)];
         else
            key = KEY_IN_W'($urandom());
         case ($urandom_range(9))
            0:       offset = '0;
            1:       offset = OFFSET_MAX;
            default: offset = OFFSET_W'($urandom());
         endcase
         sender_gap(idle_pct);
         send_op(action, key, offset);
      end
   endtask

   initial begin
      clock     = 1'b0;
      reset     = 1'b1;
      start     = 1'b0;
      req_data  = '0;
      failed    = 1'b0;
      tbl_count = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_lookup_basics();
      test_full_table();
      test_clear_and_undefined();
      drain_replies();
      test_random(230, 9);
      drain_replies();
      test_random(230, 76);
      test_random(240, 0);
      drain_replies();
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (failed)
         $display("== FAIL ==");
      else
         $display("== PASS ==");
      $finish;
   end

endmodule

/* files.f */
src/oft_pkg.sv
src/oft_ram.sv
src/oft_ctrl.sv
src/oft_dpath.sv
src/open_file_offset_table_top.sv
src/oft_checker.sv
tb/tb.sv
